### design/pal_pkg.sv
// Shared types and codes for the positional array list.
// Used by pal_cell, pal_ctrl and positional_array_list_core; depends on nothing.
package pal_pkg;

  typedef enum logic [2:0] {
    FN_INSERT    = 3'd0,
    FN_REMOVE    = 3'd1,
    FN_READ      = 3'd2,
    FN_SEARCH    = 3'd3,
    FN_OVERWRITE = 3'd4,
    FN_CLEAR     = 3'd5
  } pal_func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INS_ERR = 2'd1,
    STAT_POS_ERR = 2'd2
  } pal_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } pal_state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] value;
  } pal_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic               found;
    logic [6:0]         count;
    logic               is_empty;
    logic               is_full;
  } pal_out_t;

  // Broadcast to every cell in the cycle a list-changing word is accepted.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic               ovw;
    logic [6:0]         pos;
    logic signed [31:0] value;
  } pal_upd_t;

  // Held steady for the cells while a read or search travels down the chain.
  typedef struct packed {
    logic               rd;
    logic               srch;
    logic [6:0]         pos;
    logic signed [31:0] value;
  } pal_qry_t;

  // Handed from one cell to the next during a read or search.
  typedef struct packed {
    logic               act;
    logic               hit;
    logic signed [31:0] data;
  } pal_sweep_t;

endpackage

### design/pal_cell.sv
// One cell of the list: holds a single entry and one stage of the query chain.
// Depends on pal_pkg.
module pal_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pal_pkg::pal_upd_t     upd_i,
  input  pal_pkg::pal_qry_t     qry_i,
  input  logic [CW-1:0]         count_i,
  input  logic signed [31:0]    left_i,
  input  logic signed [31:0]    right_i,
  output logic signed [31:0]    entry_o,
  input  pal_pkg::pal_sweep_t   sweep_i,
  output pal_pkg::pal_sweep_t   sweep_o
);

  localparam int W = (CW > 7) ? CW : 7;

  logic [W-1:0]       idx_w;
  logic [W-1:0]       upos_w;
  logic [W-1:0]       qpos_w;
  logic [W-1:0]       cnt_w;
  logic signed [31:0] entry_q, entry_d;
  logic               act_q;
  logic               hit_q, hit_d;
  logic signed [31:0] data_q, data_d;

  assign idx_w  = W'(IDX);
  assign upos_w = W'(upd_i.pos);
  assign qpos_w = W'(qry_i.pos);
  assign cnt_w  = W'(count_i);

  always_comb begin
    entry_d = entry_q;
    if (upd_i.ins && (idx_w > upos_w)) begin
      entry_d = left_i;
    end else if ((upd_i.ins || upd_i.ovw) && (idx_w == upos_w)) begin
      entry_d = upd_i.value;
    end else if (upd_i.rem && (idx_w >= upos_w)) begin
      entry_d = right_i;
    end
  end

  always_comb begin
    hit_d  = sweep_i.hit;
    data_d = sweep_i.data;
    if (qry_i.srch && (idx_w < cnt_w) && (entry_q == qry_i.value)) begin
      hit_d = 1'b1;
    end
    if (qry_i.rd && (idx_w == qpos_w)) begin
      data_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
    data_q  <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= sweep_i.act;
    end
  end

  assign entry_o      = entry_q;
  assign sweep_o.act  = act_q;
  assign sweep_o.hit  = hit_q;
  assign sweep_o.data = data_q;

endmodule

### design/pal_ctrl.sv
// Control for the positional array list: handshakes, entry count, decode of
// each word and the output register. Depends on pal_pkg.
module pal_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pal_pkg::pal_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pal_pkg::pal_out_t                out_data_o,
  output pal_pkg::pal_upd_t                upd_o,
  output pal_pkg::pal_qry_t                qry_o,
  output logic [$clog2(DEPTH+1)-1:0]       count_o,
  output pal_pkg::pal_sweep_t              sweep_o,
  input  pal_pkg::pal_sweep_t              sweep_i
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int W  = (CW > 7) ? CW : 7;

  pal_pkg::pal_state_e state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                inject_q, inject_d;
  pal_pkg::pal_qry_t   qry_q, qry_d;
  logic                out_valid_q, out_valid_d;
  pal_pkg::pal_out_t   out_q, out_d;
  pal_pkg::pal_out_t   res;
  logic                load;
  logic                accept;
  logic [W-1:0]        pos_w, qpos_w, cnt_w;
  logic                ins_ok, pos_ok, qpos_ok;

  assign pos_w   = W'(in_data_i.position);
  assign qpos_w  = W'(qry_q.pos);
  assign cnt_w   = W'(count_q);
  assign ins_ok  = (count_q != CW'(DEPTH)) && (pos_w <= cnt_w);
  assign pos_ok  = pos_w < cnt_w;
  assign qpos_ok = qpos_w < cnt_w;

  assign in_stall_o = !((state_q == pal_pkg::ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    inject_d    = 1'b0;
    qry_d       = qry_q;
    load        = 1'b0;
    res         = '0;
    upd_o.ins   = 1'b0;
    upd_o.rem   = 1'b0;
    upd_o.ovw   = 1'b0;
    upd_o.pos   = in_data_i.position;
    upd_o.value = in_data_i.value;

    case (state_q)
      pal_pkg::ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (in_data_i.func)
            pal_pkg::FN_INSERT: begin
              if (ins_ok) begin
                upd_o.ins = 1'b1;
                count_d   = CW'(count_q + 1'b1);
              end else begin
                res.status = pal_pkg::STAT_INS_ERR;
              end
            end
            pal_pkg::FN_REMOVE: begin
              if (pos_ok) begin
                upd_o.rem = 1'b1;
                count_d   = CW'(count_q - 1'b1);
              end else begin
                res.status = pal_pkg::STAT_POS_ERR;
              end
            end
            pal_pkg::FN_OVERWRITE: begin
              if (pos_ok) begin
                upd_o.ovw = 1'b1;
              end else begin
                res.status = pal_pkg::STAT_POS_ERR;
              end
            end
            pal_pkg::FN_CLEAR: begin
              count_d = '0;
            end
            pal_pkg::FN_READ, pal_pkg::FN_SEARCH: begin
              load        = 1'b0;
              inject_d    = 1'b1;
              qry_d.rd    = (in_data_i.func == pal_pkg::FN_READ);
              qry_d.srch  = (in_data_i.func == pal_pkg::FN_SEARCH);
              qry_d.pos   = in_data_i.position;
              qry_d.value = in_data_i.value;
              state_d     = pal_pkg::ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      pal_pkg::ST_SWEEP: begin
        if (sweep_i.act) begin
          load    = 1'b1;
          state_d = pal_pkg::ST_IDLE;
          if (qry_q.rd && !qpos_ok) begin
            res.status = pal_pkg::STAT_POS_ERR;
          end
          res.read_value = (qry_q.rd && qpos_ok) ? sweep_i.data : 32'sd0;
          res.found      = qry_q.srch && sweep_i.hit;
        end
      end
      default: begin
        state_d = pal_pkg::ST_IDLE;
      end
    endcase

    res.count    = 7'(count_d);
    res.is_empty = (count_d == '0);
    res.is_full  = (count_d == CW'(DEPTH));

    out_valid_d = load || (out_valid_q && out_stall_i);
    out_d       = load ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pal_pkg::ST_IDLE;
      count_q     <= '0;
      inject_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      inject_q    <= inject_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qry_q <= qry_d;
    out_q <= out_d;
  end

  assign qry_o        = qry_q;
  assign count_o      = count_q;
  assign sweep_o.act  = inject_q;
  assign sweep_o.hit  = 1'b0;
  assign sweep_o.data = 32'sd0;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

endmodule

### design/positional_array_list_core.sv
// Top level of the positional array list: a row of DEPTH entry cells and
// their controller. Depends on pal_pkg, pal_cell and pal_ctrl.
//
// The list is held in a row of DEPTH cells, one entry each. Insert, remove,
// overwrite, clear and the unused codes need no sweep: every cell takes
// its neighbour's entry, the given value or its own in the cycle the word is
// accepted, so such words can be accepted back to back while the output is
// not stalled. Read and search send a query down the cell chain, one cell
// per cycle, and the next word is not accepted until the query has passed
// the last cell. The entries are not cleared at reset and there is no
// clearing pass; only entries below the current count ever reach the output.
module positional_array_list_core #(
  parameter int DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pal_pkg::pal_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pal_pkg::pal_out_t   out_data_o
);

  localparam int CW = $clog2(DEPTH + 1);

  pal_pkg::pal_upd_t   upd;
  pal_pkg::pal_qry_t   qry;
  logic [CW-1:0]       count;
  logic signed [31:0]  ent [DEPTH];
  logic signed [31:0]  lft [DEPTH];
  logic signed [31:0]  rgt [DEPTH];
  pal_pkg::pal_sweep_t sw  [DEPTH+1];

  pal_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .upd_o       (upd),
    .qry_o       (qry),
    .count_o     (count),
    .sweep_o     (sw[0]),
    .sweep_i     (sw[DEPTH])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lft[i] = ent[i];
    end else begin : g_mid_l
      assign lft[i] = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rgt[i] = ent[i];
    end else begin : g_mid_r
      assign rgt[i] = ent[i+1];
    end

    pal_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .upd_i   (upd),
      .qry_i   (qry),
      .count_i (count),
      .left_i  (lft[i]),
      .right_i (rgt[i]),
      .entry_o (ent[i]),
      .sweep_i (sw[i]),
      .sweep_o (sw[i+1])
    );
  end

endmodule

### tb/tb_positional_array_list_core.sv
// Self-checking testbench for positional_array_list_core: a list mirror predicts every
// result word, and plain tasks drive the valid/stall channels with random idling.
// Depends on pal_pkg and the positional_array_list_core RTL.
class pal_list_mirror #(int unsigned SLOTS = 64);
  logic signed [31:0] slots [SLOTS];
  int unsigned        fill;
  pal_pkg::pal_out_t  replies_due [$];
  int unsigned        mismatches;

  function new();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slots[i] = '0;
    end
    fill = 0;
    mismatches = 0;
  endfunction

  function void apply_word(pal_pkg::pal_in_t w);
    pal_pkg::pal_out_t r;
    int unsigned i;
    r = '0;
    r.status = pal_pkg::STAT_OK;
    case (w.func)
      pal_pkg::FN_INSERT: begin
        if (fill < SLOTS && w.position <= fill) begin
          for (i = fill; i > w.position; i--) begin
            slots[i] = slots[i - 1];
          end
          slots[w.position] = w.value;
          fill++;
        end else begin
          r.status = pal_pkg::STAT_INS_ERR;
        end
      end
      pal_pkg::FN_REMOVE: begin
        if (w.position < fill) begin
          for (i = w.position + 1; i < fill; i++) begin
            slots[i - 1] = slots[i];
          end
          fill--;
        end else begin
          r.status = pal_pkg::STAT_POS_ERR;
        end
      end
      pal_pkg::FN_READ: begin
        if (w.position < fill) begin
          r.read_value = slots[w.position];
        end else begin
          r.status = pal_pkg::STAT_POS_ERR;
        end
      end
      pal_pkg::FN_SEARCH: begin
        for (i = 0; i < fill; i++) begin
          if (slots[i] == w.value) begin
            r.found = 1'b1;
          end
        end
      end
      pal_pkg::FN_OVERWRITE: begin
        if (w.position < fill) begin
          slots[w.position] = w.value;
        end else begin
          r.status = pal_pkg::STAT_POS_ERR;
        end
      end
      pal_pkg::FN_CLEAR: begin
        fill = 0;
      end
      default: begin
      end
    endcase
    r.count = 7'(fill);
    r.is_empty = (fill == 0);
    r.is_full = (fill == SLOTS);
    replies_due.push_back(r);
  endfunction

  function void check_reply(pal_pkg::pal_out_t got);
    pal_pkg::pal_out_t want;
    if (replies_due.size() == 0) begin
      $error("result word %h arrived with none outstanding", got);
      mismatches++;
      return;
    end
    want = replies_due.pop_front();
    if (got.status !== want.status) begin
      $error("field status expected %0d, actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.read_value !== want.read_value) begin
      $error("field read_value expected %0d, actual %0d", want.read_value, got.read_value);
      mismatches++;
    end
    if (got.found !== want.found) begin
      $error("field found expected %0d, actual %0d", want.found, got.found);
      mismatches++;
    end
    if (got.count !== want.count) begin
      $error("field count expected %0d, actual %0d", want.count, got.count);
      mismatches++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("field is_empty expected %0d, actual %0d", want.is_empty, got.is_empty);
      mismatches++;
    end
    if (got.is_full !== want.is_full) begin
      $error("field is_full expected %0d, actual %0d", want.is_full, got.is_full);
      mismatches++;
    end
  endfunction
endclass

module tb_positional_array_list_core;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pal_pkg::pal_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pal_pkg::pal_out_t out_data_o;

  pal_list_mirror #(LIST_DEPTH) mirror;
  int unsigned send_gap_pct = 0;
  int unsigned recv_hold_pct = 0;
  int unsigned cycle_count;
  bit          filling = 1'b1;

  positional_array_list_core #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_reply(out_data_o);
    end
    out_stall_i <= (recv_hold_pct != 0) && ($urandom_range(99) < recv_hold_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic pal_pkg::pal_in_t word_of(logic [2:0] fn, int unsigned pos,
                                               logic signed [31:0] val);
    pal_pkg::pal_in_t w;
    w.func = fn;
    w.position = 7'(pos);
    w.value = val;
    return w;
  endfunction

  function automatic pal_pkg::pal_in_t next_random_word();
    pal_pkg::pal_in_t w;
    int unsigned roll;
    int unsigned fill;
    fill = mirror.fill;
    if (fill == LIST_DEPTH) begin
      filling = 1'b0;
    end else if (fill == 0) begin
      filling = 1'b1;
    end
    roll = $urandom_range(999);
    if (filling) begin
      if (roll < 450) w.func = pal_pkg::FN_INSERT;
      else if (roll < 550) w.func = pal_pkg::FN_REMOVE;
      else if (roll < 700) w.func = pal_pkg::FN_READ;
      else if (roll < 810) w.func = pal_pkg::FN_SEARCH;
      else if (roll < 980) w.func = pal_pkg::FN_OVERWRITE;
      else w.func = ($urandom_range(1) != 0) ? FN_SPARE_HI : FN_SPARE_LO;
    end else begin
      if (roll < 150) w.func = pal_pkg::FN_INSERT;
      else if (roll < 500) w.func = pal_pkg::FN_REMOVE;
      else if (roll < 650) w.func = pal_pkg::FN_READ;
      else if (roll < 770) w.func = pal_pkg::FN_SEARCH;
      else if (roll < 970) w.func = pal_pkg::FN_OVERWRITE;
      else if (roll < 980) w.func = pal_pkg::FN_CLEAR;
      else w.func = ($urandom_range(1) != 0) ? FN_SPARE_HI : FN_SPARE_LO;
    end
    if ($urandom_range(99) < 12) begin
      w.position = 7'($urandom_range(LIST_DEPTH));
    end else if (w.func == pal_pkg::FN_INSERT) begin
      w.position = 7'($urandom_range(fill));
    end else if (fill != 0) begin
      w.position = 7'($urandom_range(fill - 1));
    end else begin
      w.position = '0;
    end
    roll = $urandom_range(9);
    if (roll < 4 && fill != 0) begin
      w.value = mirror.slots[$urandom_range(fill - 1)];
    end else if (roll < 6) begin
      w.value = 32'($urandom_range(15)) - 32'd8;
    end else begin
      w.value = $urandom();
    end
    return w;
  endfunction

  task automatic send_word(input pal_pkg::pal_in_t w);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    mirror.apply_word(w);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.replies_due.size() != 0);
  endtask

  task automatic run_directed();
    send_word(word_of(pal_pkg::FN_READ, 0, 0));
    send_word(word_of(pal_pkg::FN_REMOVE, 0, 0));
    send_word(word_of(pal_pkg::FN_OVERWRITE, 0, 5));
    send_word(word_of(pal_pkg::FN_SEARCH, 0, 0));
    send_word(word_of(pal_pkg::FN_INSERT, 1, 7));
    send_word(word_of(pal_pkg::FN_INSERT, 0, VALUE_MAX));
    send_word(word_of(pal_pkg::FN_INSERT, 0, VALUE_MIN));
    send_word(word_of(pal_pkg::FN_INSERT, 2, -1));
    send_word(word_of(pal_pkg::FN_INSERT, 1, 0));
    send_word(word_of(pal_pkg::FN_READ, 0, 0));
    send_word(word_of(pal_pkg::FN_READ, 1, 0));
    send_word(word_of(pal_pkg::FN_READ, 2, 0));
    send_word(word_of(pal_pkg::FN_READ, 3, 0));
    send_word(word_of(pal_pkg::FN_READ, 4, 0));
    send_word(word_of(pal_pkg::FN_SEARCH, 0, VALUE_MIN));
    send_word(word_of(pal_pkg::FN_SEARCH, 0, 12345));
    send_word(word_of(pal_pkg::FN_OVERWRITE, 3, 32'sh5555_5555));
    send_word(word_of(pal_pkg::FN_REMOVE, 0, 0));
    send_word(word_of(pal_pkg::FN_REMOVE, 2, 0));
    send_word(word_of(FN_SPARE_LO, 0, -1));
    send_word(word_of(FN_SPARE_HI, LIST_DEPTH, VALUE_MAX));
    send_word(word_of(pal_pkg::FN_READ, LIST_DEPTH, 0));
    send_word(word_of(pal_pkg::FN_INSERT, LIST_DEPTH, 1));
    send_word(word_of(pal_pkg::FN_CLEAR, 0, 0));
    send_word(word_of(pal_pkg::FN_SEARCH, 0, 0));
  endtask

  task automatic run_random(input int unsigned words, input int unsigned gap_pct,
                            input int unsigned hold_pct);
    int unsigned n;
    send_gap_pct = gap_pct;
    recv_hold_pct = hold_pct;
    for (n = 0; n < words; n++) begin
      send_word(next_random_word());
    end
  endtask

  initial begin
    mirror = new();
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(430, 26, 58);
    hold_until_drained();
    run_random(430, 58, 26);
    hold_until_drained();
    run_random(440, 0, 0);
    in_valid_i <= 1'b0;
    while (mirror.replies_due.size() != 0) @(posedge clk_i);
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (mirror.replies_due.size() != 0) begin
      $error("%0d result words never arrived", mirror.replies_due.size());
    end
    if (mirror.mismatches == 0 && mirror.replies_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
